### rtl/perceptron_fixed_increment_trainer_core_defines.svh
// Assertion macros shared by the trainer RTL.
`ifndef PERCEPTRON_FIXED_INCREMENT_TRAINER_CORE_DEFINES_SVH
`define PERCEPTRON_FIXED_INCREMENT_TRAINER_CORE_DEFINES_SVH

// The consequence must hold in the same cycle as the condition.
`define PFIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define PFIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pfit_pkg.sv
package pfit_pkg;

    localparam int COMPONENTS = 3;

    localparam int FEATURE_W = 8;
    localparam int WEIGHT_W  = 24;
    localparam int WIDE_W    = WEIGHT_W + 1;
    localparam int PROD_W    = WEIGHT_W + FEATURE_W;
    localparam int SCORE_W   = 34;
    localparam int RATE_W    = 4;
    localparam int DELTA_W   = RATE_W + 1 + FEATURE_W;
    localparam int SIZE_W    = 8;
    localparam int POS_W     = 8;
    localparam int RUN_W     = 8;
    localparam int PASS_W    = 16;

    localparam int NUM_REGS  = 2 + COMPONENTS;
    localparam int REG_IDX_W = $clog2(NUM_REGS + 1);
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int DATA_W    = 32;
    localparam int WIDX_W    = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

    localparam logic [REG_IDX_W-1:0] REG_SET_SIZE      = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_LEARN_RATE    = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_INIT_WEIGHT_0 = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_END           = REG_IDX_W'(NUM_REGS);

    typedef logic signed [WEIGHT_W-1:0]  weight_t;
    typedef logic signed [FEATURE_W-1:0] feature_t;
    typedef weight_t  [COMPONENTS-1:0]   weight_vec_t;
    typedef feature_t [COMPONENTS-1:0]   feature_vec_t;

    localparam weight_t WEIGHT_RESET = WEIGHT_W'(1);
    localparam weight_t WEIGHT_MAX   = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam weight_t WEIGHT_MIN   = {1'b1, {(WEIGHT_W-1){1'b0}}};
    localparam logic [SIZE_W-1:0] SET_SIZE_RESET   = SIZE_W'(4);
    localparam logic [RATE_W-1:0] LEARN_RATE_RESET = RATE_W'(1);

    typedef enum logic [1:0] {
        SIGN_POS  = 2'd0,
        SIGN_ZERO = 2'd1,
        SIGN_NEG  = 2'd2
    } sign_code_t;

    typedef struct packed {
        logic [SIZE_W-1:0] set_size;
        logic [RATE_W-1:0] learn_rate;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [WIDX_W-1:0] idx;
        weight_t           value;
    } preset_t;

    typedef struct packed {
        weight_vec_t       weights;
        logic [RUN_W-1:0]  correct_run;
        logic [POS_W-1:0]  position;
        logic [PASS_W-1:0] passes;
        logic              done;
    } state_t;

    typedef struct packed {
        feature_vec_t features;
        logic         class_negative;
    } sample_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        sign_code_t                sign_code;
        logic                      misclassified;
        weight_vec_t               new_weights;
        logic [POS_W-1:0]          sample_position;
        logic [PASS_W-1:0]         pass_number;
        logic                      converged;
    } result_t;

endpackage

### rtl/pfit_regs.sv
module pfit_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pfit_pkg::ADDR_W-1:0]  paddr,
    input  logic [pfit_pkg::DATA_W-1:0]  pwdata,
    output logic [pfit_pkg::DATA_W-1:0]  prdata,
    output pfit_pkg::cfg_t               cfg,
    output pfit_pkg::preset_t            preset
);

    logic [pfit_pkg::SIZE_W-1:0] set_size_reg;
    logic [pfit_pkg::RATE_W-1:0] learn_rate_reg;
    pfit_pkg::weight_vec_t       init_weight_reg;

    logic [pfit_pkg::REG_IDX_W-1:0] reg_idx;
    logic [pfit_pkg::REG_IDX_W-1:0] weight_off;
    logic [pfit_pkg::WIDX_W-1:0]    weight_idx;
    logic                           is_weight;
    logic                           wr_en;
    pfit_pkg::weight_t              rd_weight;

    assign reg_idx    = paddr[pfit_pkg::ADDR_W-1:2];
    assign weight_off = reg_idx - pfit_pkg::REG_INIT_WEIGHT_0;
    assign weight_idx = weight_off[pfit_pkg::WIDX_W-1:0];
    assign is_weight  = (reg_idx >= pfit_pkg::REG_INIT_WEIGHT_0) && (reg_idx < pfit_pkg::REG_END);
    assign wr_en      = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg   <= pfit_pkg::SET_SIZE_RESET;
            learn_rate_reg <= pfit_pkg::LEARN_RATE_RESET;
            for (int i = 0; i < pfit_pkg::COMPONENTS; i++)
            begin
                init_weight_reg[i] <= pfit_pkg::WEIGHT_RESET;
            end
        end
        else if (wr_en)
        begin
            if (reg_idx == pfit_pkg::REG_SET_SIZE)
            begin
                set_size_reg <= pwdata[pfit_pkg::SIZE_W-1:0];
            end
            else if (reg_idx == pfit_pkg::REG_LEARN_RATE)
            begin
                learn_rate_reg <= pwdata[pfit_pkg::RATE_W-1:0];
            end
            else if (is_weight)
            begin
                init_weight_reg[weight_idx] <= pwdata[pfit_pkg::WEIGHT_W-1:0];
            end
        end
    end

    assign rd_weight = is_weight ? init_weight_reg[weight_idx] : '0;

    always_comb
    begin
        if (reg_idx == pfit_pkg::REG_SET_SIZE)
        begin
            prdata = {{(pfit_pkg::DATA_W-pfit_pkg::SIZE_W){1'b0}}, set_size_reg};
        end
        else if (reg_idx == pfit_pkg::REG_LEARN_RATE)
        begin
            prdata = {{(pfit_pkg::DATA_W-pfit_pkg::RATE_W){1'b0}}, learn_rate_reg};
        end
        else
        begin
            prdata = {{(pfit_pkg::DATA_W-pfit_pkg::WEIGHT_W){rd_weight[pfit_pkg::WEIGHT_W-1]}},
                      rd_weight};
        end
    end

    assign cfg.set_size   = set_size_reg;
    assign cfg.learn_rate = learn_rate_reg;

    // Writing an initial weight also loads the live weight at once.
    assign preset.en    = wr_en && is_weight;
    assign preset.idx   = weight_idx;
    assign preset.value = pwdata[pfit_pkg::WEIGHT_W-1:0];

endmodule

### rtl/pfit_step.sv
module pfit_step
(
    input  pfit_pkg::state_t  state,
    input  pfit_pkg::sample_t sample,
    input  pfit_pkg::cfg_t    cfg,
    output pfit_pkg::state_t  state_next,
    output pfit_pkg::result_t result
);

    logic signed [pfit_pkg::PROD_W-1:0]  prod  [pfit_pkg::COMPONENTS];
    logic signed [pfit_pkg::DELTA_W-1:0] delta [pfit_pkg::COMPONENTS];
    logic signed [pfit_pkg::WIDE_W-1:0]  wide  [pfit_pkg::COMPONENTS];
    pfit_pkg::weight_vec_t               corrected;
    logic signed [pfit_pkg::SCORE_W-1:0] score_sum;
    logic [pfit_pkg::SIZE_W-1:0]         size;
    logic [pfit_pkg::POS_W:0]            pos_inc;
    logic [pfit_pkg::RUN_W-1:0]          run_inc;
    logic                                score_neg;
    logic                                score_zero;
    logic                                wrong_raw;
    logic                                wrong;
    pfit_pkg::sign_code_t                sign_code;

    assign size = (cfg.set_size == '0) ? pfit_pkg::SIZE_W'(1) : cfg.set_size;

    always_comb
    begin
        score_sum = '0;
        for (int i = 0; i < pfit_pkg::COMPONENTS; i++)
        begin
            prod[i]   = $signed(state.weights[i]) * $signed(sample.features[i]);
            score_sum = score_sum + pfit_pkg::SCORE_W'(prod[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < pfit_pkg::COMPONENTS; i++)
        begin
            delta[i] = $signed({1'b0, cfg.learn_rate}) * $signed(sample.features[i]);
            if (sample.class_negative)
            begin
                wide[i] = pfit_pkg::WIDE_W'($signed(state.weights[i]))
                        - pfit_pkg::WIDE_W'(delta[i]);
            end
            else
            begin
                wide[i] = pfit_pkg::WIDE_W'($signed(state.weights[i]))
                        + pfit_pkg::WIDE_W'(delta[i]);
            end
            if (wide[i][pfit_pkg::WIDE_W-1] != wide[i][pfit_pkg::WIDE_W-2])
            begin
                corrected[i] = wide[i][pfit_pkg::WIDE_W-1] ? pfit_pkg::WEIGHT_MIN
                                                            : pfit_pkg::WEIGHT_MAX;
            end
            else
            begin
                corrected[i] = wide[i][pfit_pkg::WEIGHT_W-1:0];
            end
        end
    end

    assign score_neg  = score_sum[pfit_pkg::SCORE_W-1];
    assign score_zero = (score_sum == '0);
    assign wrong_raw  = sample.class_negative ? !score_neg : (score_neg || score_zero);
    assign wrong      = wrong_raw && !state.done;

    always_comb
    begin
        if (score_neg)
        begin
            sign_code = pfit_pkg::SIGN_NEG;
        end
        else if (score_zero)
        begin
            sign_code = pfit_pkg::SIGN_ZERO;
        end
        else
        begin
            sign_code = pfit_pkg::SIGN_POS;
        end
    end

    assign run_inc = (state.correct_run != '1) ? state.correct_run + 1'b1 : state.correct_run;
    assign pos_inc = {1'b0, state.position} + 1'b1;

    always_comb
    begin
        state_next = state;
        if ((state.position == '0) && (state.passes != '1))
        begin
            state_next.passes = state.passes + 1'b1;
        end
        if (!state.done)
        begin
            if (wrong_raw)
            begin
                state_next.weights     = corrected;
                state_next.correct_run = '0;
            end
            else
            begin
                state_next.correct_run = run_inc;
                if (run_inc >= size)
                begin
                    state_next.done = 1'b1;
                end
            end
        end
        if (pos_inc >= {1'b0, size})
        begin
            state_next.position = '0;
        end
        else
        begin
            state_next.position = pos_inc[pfit_pkg::POS_W-1:0];
        end
    end

    assign result.score           = score_sum;
    assign result.sign_code       = sign_code;
    assign result.misclassified   = wrong;
    assign result.new_weights     = state_next.weights;
    assign result.sample_position = state.position;
    assign result.pass_number     = state_next.passes;
    assign result.converged       = state_next.done;

endmodule

### rtl/perceptron_fixed_increment_trainer_core.sv
// Perceptron trainer using the fixed-increment rule. Each input beat is one
// augmented sample; each output beat reports the score of the weights held
// before that sample, its sign, whether the weights were corrected, the weights
// after the step, the sample's position in the pass, the pass number and the
// converged flag. The block takes one beat per cycle unless out_ready stalls
// it: a beat sits in an input register, and combinational multiply, sum and
// update logic writes the weights and the output register together, so a
// result is offered once its beat moves from the input to the output register.
// in_ready drops only while both registers hold a beat and out_ready is low.
// Writing an initial weight through the APB port also loads that live weight
// at once; configure only while no beat is in flight.
`include "perceptron_fixed_increment_trainer_core_defines.svh"

module perceptron_fixed_increment_trainer_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pfit_pkg::ADDR_W-1:0]           paddr,
    input  logic [pfit_pkg::DATA_W-1:0]           pwdata,
    output logic [pfit_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pfit_pkg::FEATURE_W-1:0] feature_0,
    input  logic signed [pfit_pkg::FEATURE_W-1:0] feature_1,
    input  logic signed [pfit_pkg::FEATURE_W-1:0] feature_2,
    input  logic                                  class_negative,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pfit_pkg::SCORE_W-1:0]   score,
    output logic [1:0]                            sign_code,
    output logic                                  misclassified,
    output logic signed [pfit_pkg::WEIGHT_W-1:0]  new_weight_0,
    output logic signed [pfit_pkg::WEIGHT_W-1:0]  new_weight_1,
    output logic signed [pfit_pkg::WEIGHT_W-1:0]  new_weight_2,
    output logic [pfit_pkg::POS_W-1:0]            sample_position,
    output logic [pfit_pkg::PASS_W-1:0]           pass_number,
    output logic                                  converged
);

    pfit_pkg::cfg_t    cfg;
    pfit_pkg::preset_t cfg_preset;
    pfit_pkg::sample_t sample_in;
    pfit_pkg::sample_t sample_reg;
    pfit_pkg::state_t  state_reg;
    pfit_pkg::state_t  state_next;
    pfit_pkg::result_t result_reg;
    pfit_pkg::result_t result_next;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              load;

    pfit_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .preset  (cfg_preset)
    );

    assign pready = 1'b1;

    assign sample_in.features[0]    = feature_0;
    assign sample_in.features[1]    = feature_1;
    assign sample_in.features[2]    = feature_2;
    assign sample_in.class_negative = class_negative;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= sample_in;
        end
    end

    pfit_step u_step
    (
        .state      (state_reg),
        .sample     (sample_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pfit_pkg::COMPONENTS; i++)
            begin
                state_reg.weights[i] <= pfit_pkg::WEIGHT_RESET;
            end
            state_reg.correct_run <= '0;
            state_reg.position    <= '0;
            state_reg.passes      <= '0;
            state_reg.done        <= 1'b0;
        end
        else if (cfg_preset.en)
        begin
            state_reg.weights[cfg_preset.idx] <= cfg_preset.value;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign score           = result_reg.score;
    assign sign_code       = result_reg.sign_code;
    assign misclassified   = result_reg.misclassified;
    assign new_weight_0    = result_reg.new_weights[0];
    assign new_weight_1    = result_reg.new_weights[1];
    assign new_weight_2    = result_reg.new_weights[2];
    assign sample_position = result_reg.sample_position;
    assign pass_number     = result_reg.pass_number;
    assign converged       = result_reg.converged;

    `PFIT_ASSERT_NEXT(a_done_sticky, state_reg.done, state_reg.done, "converged flag cleared")
    `PFIT_ASSERT_NEXT(a_weights_frozen, state_reg.done && !cfg_preset.en, $stable(state_reg.weights), "weights moved after convergence")
    `PFIT_ASSERT_NOW(a_miss_not_conv, out_valid_reg && result_reg.misclassified, !result_reg.converged, "corrected beat reports convergence")

endmodule
